// ===== src/svm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svm_pkg
// Shared types, constants and helpers for the sample voice mixer.
// ----------------------------------------------------------------------------
package svm_pkg;

	// position format defaults (integer and fraction bits)
	localparam int POS_INT_BITS_DEF  = 20;
	localparam int POS_FRAC_BITS_DEF = 16;

	// configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 21;

	// field widths
	localparam int SAMPLE_W = 16;
	localparam int INDEX_W  = 20;
	localparam int VOL_W    = 14;
	localparam int PAN_W    = 13;
	localparam int STEP_W   = 21;
	localparam int GAIN_W   = VOL_W + PAN_W;
	localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;

	// register reset values
	localparam logic [VOL_W-1:0]  VOLUME_RST = 14'd4096;
	localparam logic [PAN_W-1:0]  PAN_RST    = 13'd2048;
	localparam logic [STEP_W-1:0] STEP_RST   = 21'd65536;

	// pan law points
	localparam logic [PAN_W-1:0] PAN_FULL   = 13'd4096;
	localparam logic [PAN_W-1:0] PAN_CENTER = 13'd2048;
	localparam logic [PAN_W-1:0] UNITY_Q12  = 13'd4096;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_VOLUME_GAIN    = 3'd0,
		REG_PAN_POSITION   = 3'd1,
		REG_STEP_INCREMENT = 3'd2,
		REG_LOOP_START     = 3'd3,
		REG_LOOP_END       = 3'd4,
		REG_DATA_END       = 3'd5,
		REG_LOOP_ENABLE    = 3'd6,
		REG_FORMAT_MODE    = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GAIN,
		ST_PROD,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [VOL_W-1:0]   volume_gain;
		logic [PAN_W-1:0]   pan_position;
		logic [STEP_W-1:0]  step_increment;
		logic [INDEX_W-1:0] loop_start;
		logic [INDEX_W-1:0] loop_end;
		logic [INDEX_W-1:0] data_end;
		logic               loop_enable;
		logic [1:0]         format_mode;
	} cfg_t;

	typedef struct packed {
		logic                       req_type;
		logic [INDEX_W-1:0]         start_position;
		logic signed [SAMPLE_W-1:0] sample_first;
		logic signed [SAMPLE_W-1:0] sample_second;
		logic signed [SAMPLE_W-1:0] mix_left_in;
		logic signed [SAMPLE_W-1:0] mix_right_in;
		logic                       buffer_last;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] mix_left_out;
		logic signed [SAMPLE_W-1:0] mix_right_out;
		logic [INDEX_W-1:0]         fetch_index;
		logic                       voice_active;
		logic                       buffer_last_out;
	} out_word_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic gain;
		logic prod;
		logic fin;
	} cmd_t;

	// 16-bit signed, or 8-bit unsigned byte mapped to (127 - s) * 256
	function automatic logic signed [SAMPLE_W-1:0] sample_value(
		input logic [SAMPLE_W-1:0] raw,
		input logic                wide16
	);
		logic [7:0] b;
		b = 8'd127 - raw[7:0];
		if (wide16) begin
			sample_value = $signed(raw);
		end else begin
			sample_value = $signed({b, 8'h00});
		end
	endfunction

	// mix + product / 2^24, rounded toward zero, saturated to 16 bits
	function automatic logic signed [SAMPLE_W-1:0] mix_one(
		input logic signed [SAMPLE_W-1:0] mix,
		input logic signed [PROD_W-1:0]   prod
	);
		logic signed [45:0] t;
		logic signed [21:0] r;
		t = $signed({{6{mix[15]}}, mix, 24'd0}) + 46'(prod);
		if (t[45]) begin
			t = t + 46'sd16777215;
		end
		r = t[45:24];
		if (r > 22'sd32767) begin
			mix_one = 16'sh7fff;
		end else if (r < -22'sd32768) begin
			mix_one = 16'sh8000;
		end else begin
			mix_one = r[15:0];
		end
	endfunction

endpackage
`default_nettype wire

// ===== src/sample_voice_mixer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// a result word is registered in the finish step, after the gain and product steps
// a new word is taken only once the sequencer is back in idle after stepping through
//   gain multiply, sample multiply and mix / position finish; finish waits while the
//   output register is still held by a stalled consumer
// reset: registers return to their defaults, play position zero, voice idle
// ----------------------------------------------------------------------------
// sample_voice_mixer_core
// One PCM sample playback voice with volume, linear pan and looping, mixed
// into a running stereo stream.
// ----------------------------------------------------------------------------
module sample_voice_mixer_core #(
	parameter int POS_INT_BITS  = svm_pkg::POS_INT_BITS_DEF,
	parameter int POS_FRAC_BITS = svm_pkg::POS_FRAC_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// input words: fetched samples plus the running mix
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  svm_pkg::in_word_t                    in_word,
	// result words: updated mix and next fetch index
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output svm_pkg::out_word_t                   out_word,
	// register writes
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [svm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [svm_pkg::CFG_DATA_W-1:0]  cfg_data
);

	svm_pkg::cfg_t cfg;
	svm_pkg::cmd_t cmd;

	// register file; writes must be made only while no word is in flight; the block does not enforce this
	svm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer: idle -> gain -> product -> finish, holding in finish
	// while the output register still holds a result that the consumer stalls
	svm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// datapath: pan gains (Q24), scaled samples, saturating mix, and the
	// fixed point position with loop wrap and data end handling
	svm_dpath #(
		.POS_INT_BITS  (POS_INT_BITS),
		.POS_FRAC_BITS (POS_FRAC_BITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.in_word  (in_word),
		.out_word (out_word)
	);

	// an accepted word keeps the input side busy for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accepting a word");

	// a new result only appears from the finish step, never from idle
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result word raised without a word in flight");

	// finish is never issued over an unread, stalled result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> !(out_valid && out_stall))
		else $error("result register overwritten while stalled");

endmodule
`default_nettype wire

// ===== src/svm_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svm_cfg
// Configuration register file, written through a valid/ready port.
// ----------------------------------------------------------------------------
module svm_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [svm_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [svm_pkg::CFG_DATA_W-1:0]     cfg_data,
	output svm_pkg::cfg_t                           cfg
);

	svm_pkg::cfg_t cfg_q;

	// writes must land only while the voice is idle; the block does not enforce this and is always ready
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.volume_gain    <= svm_pkg::VOLUME_RST;
			cfg_q.pan_position   <= svm_pkg::PAN_RST;
			cfg_q.step_increment <= svm_pkg::STEP_RST;
			cfg_q.loop_start     <= '0;
			cfg_q.loop_end       <= '0;
			cfg_q.data_end       <= '0;
			cfg_q.loop_enable    <= 1'b0;
			cfg_q.format_mode    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (svm_pkg::reg_idx_t'(cfg_index))
				svm_pkg::REG_VOLUME_GAIN: begin
					cfg_q.volume_gain <= cfg_data[svm_pkg::VOL_W-1:0];
				end
				svm_pkg::REG_PAN_POSITION: begin
					cfg_q.pan_position <= cfg_data[svm_pkg::PAN_W-1:0];
				end
				svm_pkg::REG_STEP_INCREMENT: begin
					cfg_q.step_increment <= cfg_data[svm_pkg::STEP_W-1:0];
				end
				svm_pkg::REG_LOOP_START: begin
					cfg_q.loop_start <= cfg_data[svm_pkg::INDEX_W-1:0];
				end
				svm_pkg::REG_LOOP_END: begin
					cfg_q.loop_end <= cfg_data[svm_pkg::INDEX_W-1:0];
				end
				svm_pkg::REG_DATA_END: begin
					cfg_q.data_end <= cfg_data[svm_pkg::INDEX_W-1:0];
				end
				svm_pkg::REG_LOOP_ENABLE: begin
					cfg_q.loop_enable <= cfg_data[0];
				end
				svm_pkg::REG_FORMAT_MODE: begin
					cfg_q.format_mode <= cfg_data[1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== src/svm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svm_ctrl
// Sequencer: gain multiply, sample multiply, mix and position finish.
// ----------------------------------------------------------------------------
module svm_ctrl (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	output logic         out_valid,
	input  wire logic    out_stall,
	output svm_pkg::cmd_t cmd
);

	svm_pkg::state_t state_q;
	svm_pkg::state_t state_nxt;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= svm_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			svm_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = svm_pkg::ST_GAIN;
				end
			end
			svm_pkg::ST_GAIN: begin
				cmd.gain  = 1'b1;
				state_nxt = svm_pkg::ST_PROD;
			end
			svm_pkg::ST_PROD: begin
				cmd.prod  = 1'b1;
				state_nxt = svm_pkg::ST_FIN;
			end
			svm_pkg::ST_FIN: begin
				// wait while the previous word still sits in the output register and the consumer stalls
				if (!out_valid_q || !out_stall) begin
					cmd.fin   = 1'b1;
					state_nxt = svm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = svm_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != svm_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== src/svm_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svm_dpath
// Gain and mix arithmetic, play position and voice state.
// ----------------------------------------------------------------------------
module svm_dpath #(
	parameter int POS_INT_BITS  = svm_pkg::POS_INT_BITS_DEF,
	parameter int POS_FRAC_BITS = svm_pkg::POS_FRAC_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  svm_pkg::cfg_t          cfg,
	input  svm_pkg::cmd_t          cmd,
	input  svm_pkg::in_word_t      in_word,
	output svm_pkg::out_word_t     out_word
);

	localparam int PW = POS_INT_BITS + POS_FRAC_BITS;
	// room for the unwrapped sum and the scaled loop / data end points
	localparam int CW = PW + 24;
	localparam int SL = (POS_FRAC_BITS >= 16) ? (POS_FRAC_BITS - 16) : 0;
	localparam int SR = (POS_FRAC_BITS >= 16) ? 0 : (16 - POS_FRAC_BITS);
	localparam int IW = svm_pkg::INDEX_W;
	localparam int GW = svm_pkg::GAIN_W;

	svm_pkg::in_word_t  in_q;
	logic               start_q;
	logic               mix_q;
	logic               pos_en_q;
	logic [PW-1:0]      pos_q;
	logic               active_q;
	logic [CW-1:0]      np_s1;
	logic [GW-1:0]      gain_l_s1;
	logic [GW-1:0]      gain_r_s1;
	logic signed [svm_pkg::PROD_W-1:0] prod_l_s2;
	logic signed [svm_pkg::PROD_W-1:0] prod_r_s2;
	svm_pkg::out_word_t out_q;

	logic                stereo;
	logic [CW-1:0]       step_cw;
	logic [CW-1:0]       step_mul;
	logic [IW:0]         ls_mul;
	logic [IW:0]         le_mul;
	logic [CW-1:0]       ls_pos;
	logic [CW-1:0]       le_pos;
	logic [CW-1:0]       de_pos;
	logic [svm_pkg::PAN_W-1:0] pan_c;
	logic [svm_pkg::PAN_W-1:0] lf;
	logic [svm_pkg::PAN_W-1:0] rf;
	logic signed [svm_pkg::SAMPLE_W-1:0] sl;
	logic signed [svm_pkg::SAMPLE_W-1:0] sr;
	logic                wrap;
	logic [PW-1:0]       pos_fin;
	logic                act_fin;
	logic [IW-1:0]       idx;

	assign stereo   = cfg.format_mode[0];
	assign step_cw  = (CW'(cfg.step_increment) << SL) >> SR;
	assign step_mul = stereo ? (step_cw << 1) : step_cw;
	assign ls_mul   = stereo ? {cfg.loop_start, 1'b0} : {1'b0, cfg.loop_start};
	assign le_mul   = stereo ? {cfg.loop_end, 1'b0} : {1'b0, cfg.loop_end};
	assign ls_pos   = CW'(ls_mul) << POS_FRAC_BITS;
	assign le_pos   = CW'(le_mul) << POS_FRAC_BITS;
	assign de_pos   = CW'(cfg.data_end) << POS_FRAC_BITS;

	// linear pan law, pan clamped to full right
	always_comb begin
		pan_c = (cfg.pan_position > svm_pkg::PAN_FULL) ? svm_pkg::PAN_FULL : cfg.pan_position;
		if (pan_c >= svm_pkg::PAN_CENTER) begin
			lf = 13'(14'd8192 - {pan_c, 1'b0});
			rf = svm_pkg::UNITY_Q12;
		end else begin
			lf = svm_pkg::UNITY_Q12;
			rf = {pan_c[svm_pkg::PAN_W-2:0], 1'b0};
		end
	end

	assign sl = svm_pkg::sample_value(in_q.sample_first, cfg.format_mode[1]);
	assign sr = stereo ? svm_pkg::sample_value(in_q.sample_second, cfg.format_mode[1]) : sl;

	assign wrap = !start_q && (cfg.loop_end != '0) && (np_s1 >= le_pos);

	// data end: restart once at the loop start, or stop the voice
	always_comb begin
		pos_fin = pos_q;
		act_fin = active_q;
		if (pos_en_q && (CW'(pos_q) >= de_pos)) begin
			if (cfg.loop_enable) begin
				pos_fin = ls_pos[PW-1:0];
			end else begin
				act_fin = 1'b0;
			end
		end
		idx = IW'(pos_fin[PW-1:POS_FRAC_BITS]);
		if (stereo) begin
			idx[0] = 1'b0;
		end
	end

	// voice state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			active_q <= 1'b0;
		end else begin
			if (cmd.prod && pos_en_q) begin
				pos_q <= wrap ? ls_pos[PW-1:0] : np_s1[PW-1:0];
				if (start_q) begin
					active_q <= 1'b1;
				end
			end
			if (cmd.fin) begin
				pos_q    <= pos_fin;
				active_q <= act_fin;
			end
		end
	end

	// word and arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q     <= in_word;
			start_q  <= in_word.req_type;
			mix_q    <= !in_word.req_type && active_q;
			pos_en_q <= in_word.req_type || active_q;
		end
		if (cmd.gain) begin
			np_s1     <= start_q ? (CW'(in_q.start_position) << POS_FRAC_BITS)
			                     : (CW'(pos_q) + step_mul);
			gain_l_s1 <= GW'(cfg.volume_gain) * GW'(lf);
			gain_r_s1 <= GW'(cfg.volume_gain) * GW'(rf);
		end
		if (cmd.prod) begin
			prod_l_s2 <= sl * $signed({1'b0, gain_l_s1});
			prod_r_s2 <= sr * $signed({1'b0, gain_r_s1});
		end
		if (cmd.fin) begin
			out_q.mix_left_out    <= mix_q ? svm_pkg::mix_one(in_q.mix_left_in, prod_l_s2)
			                               : in_q.mix_left_in;
			out_q.mix_right_out   <= mix_q ? svm_pkg::mix_one(in_q.mix_right_in, prod_r_s2)
			                               : in_q.mix_right_in;
			out_q.fetch_index     <= idx;
			out_q.voice_active    <= act_fin;
			out_q.buffer_last_out <= in_q.buffer_last;
		end
	end

	assign out_word = out_q;

endmodule
`default_nettype wire

// ===== tb/svm_mix_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_mix_checker
// Watches the word, result and register channels of the voice mixer. It
// keeps its own model of the voice, predicts every result word and compares
// each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module svm_mix_checker
	import svm_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	input  wire logic                   in_stall,
	input  in_word_t                    in_word,
	input  wire logic                   out_valid,
	input  wire logic                   out_stall,
	input  out_word_t                   out_word,
	input  wire logic                   cfg_valid,
	input  wire logic                   cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	output int                          fail_count,
	output int                          words_pending
);

	typedef longint unsigned u64_t;

	localparam int   FRAC_BITS = POS_FRAC_BITS_DEF;
	localparam int   POS_W     = POS_INT_BITS_DEF + POS_FRAC_BITS_DEF;
	localparam u64_t POS_MASK  = (u64_t'(1) << POS_W) - 1;
	localparam longint Q24     = 64'sd16777216;

	// shadow registers
	logic [VOL_W-1:0]   vol;
	logic [PAN_W-1:0]   pan;
	logic [STEP_W-1:0]  step;
	logic [INDEX_W-1:0] lp_start;
	logic [INDEX_W-1:0] lp_end;
	logic [INDEX_W-1:0] dat_end;
	logic               lp_en;
	logic [1:0]         fmt;

	// voice state
	u64_t play_pos;
	logic playing;

	out_word_t predicted_q[$];
	out_word_t oldest;
	int        mismatches;

	function automatic u64_t frames_to_pos(input u64_t frames);
		return frames << FRAC_BITS;
	endfunction

	function automatic longint sample_of(input logic [SAMPLE_W-1:0] raw);
		if (fmt[1])
			return longint'($signed(raw));
		return (127 - longint'(raw[7:0])) * 256;
	endfunction

	// mix plus sample times Q24 gain, toward zero, clamped to 16 bits
	function automatic logic [SAMPLE_W-1:0] mix_add(
		input logic signed [SAMPLE_W-1:0] mix,
		input longint                     smp,
		input longint                     gain
	);
		longint t;
		longint r;
		t = longint'(mix) * Q24 + smp * gain;
		r = t / Q24;
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r[SAMPLE_W-1:0];
	endfunction

	function automatic void data_end_check();
		u64_t mul;
		mul = u64_t'(fmt[0] ? 2 : 1);
		if (play_pos >= frames_to_pos(u64_t'(dat_end))) begin
			if (lp_en)
				play_pos = frames_to_pos(u64_t'(lp_start) * mul) & POS_MASK;
			else
				playing = 1'b0;
		end
	endfunction

	function automatic u64_t step_in_pos();
		if (FRAC_BITS >= 16)
			return u64_t'(step) << (FRAC_BITS - 16);
		return u64_t'(step) >> (16 - FRAC_BITS);
	endfunction

	// one frame of the voice: updates the model state, returns the result word
	function automatic out_word_t voice_frame(input in_word_t w);
		out_word_t          o;
		u64_t               mul;
		u64_t               np;
		int unsigned        p;
		longint             lf;
		longint             rf;
		longint             sl;
		longint             sr;
		logic [INDEX_W-1:0] idx;
		o.mix_left_out  = w.mix_left_in;
		o.mix_right_out = w.mix_right_in;
		mul = u64_t'(fmt[0] ? 2 : 1);
		if (w.req_type) begin
			play_pos = frames_to_pos(u64_t'(w.start_position)) & POS_MASK;
			playing  = 1'b1;
			data_end_check();
		end else if (playing) begin
			p  = (pan > 4096) ? 4096 : pan;
			lf = (p >= 2048) ? longint'(8192 - 2 * p) : 4096;
			rf = (p >= 2048) ? 4096 : longint'(2 * p);
			sl = sample_of(w.sample_first);
			sr = fmt[0] ? sample_of(w.sample_second) : sl;
			o.mix_left_out  = mix_add(w.mix_left_in, sl, longint'(vol) * lf);
			o.mix_right_out = mix_add(w.mix_right_in, sr, longint'(vol) * rf);
			// loop wrap compares the sum before it wraps to the position width
			np = play_pos + step_in_pos() * mul;
			if (lp_end != 0 && np >= frames_to_pos(u64_t'(lp_end) * mul))
				np = frames_to_pos(u64_t'(lp_start) * mul);
			play_pos = np & POS_MASK;
			data_end_check();
		end
		idx = INDEX_W'(play_pos >> FRAC_BITS);
		if (fmt[0])
			idx[0] = 1'b0;
		o.fetch_index     = idx;
		o.voice_active    = playing;
		o.buffer_last_out = w.buffer_last;
		return o;
	endfunction

	function automatic void store_reg(
		input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0]  data
	);
		case (reg_idx_t'(idx))
			REG_VOLUME_GAIN:    vol      = data[VOL_W-1:0];
			REG_PAN_POSITION:   pan      = data[PAN_W-1:0];
			REG_STEP_INCREMENT: step     = data[STEP_W-1:0];
			REG_LOOP_START:     lp_start = data[INDEX_W-1:0];
			REG_LOOP_END:       lp_end   = data[INDEX_W-1:0];
			REG_DATA_END:       dat_end  = data[INDEX_W-1:0];
			REG_LOOP_ENABLE:    lp_en    = data[0];
			REG_FORMAT_MODE:    fmt      = data[1:0];
			default: ;
		endcase
	endfunction

	task automatic check_field(input string fld, input longint want, input longint got);
		if (want != got) begin
			mismatches++;
			$display("%t: %s mismatch, expected %0d, actual %0d", $time, fld, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol        = VOLUME_RST;
			pan        = PAN_RST;
			step       = STEP_RST;
			lp_start   = '0;
			lp_end     = '0;
			dat_end    = '0;
			lp_en      = 1'b0;
			fmt        = 2'd0;
			play_pos   = '0;
			playing    = 1'b0;
			mismatches = 0;
			predicted_q.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				store_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				predicted_q.push_back(voice_frame(in_word));
			if (out_valid && !out_stall) begin
				if (predicted_q.size() == 0) begin
					mismatches++;
					$display("%t: result word %h arrived with nothing predicted",
						$time, out_word);
				end else begin
					oldest = predicted_q.pop_front();
					check_field("mix_left_out", oldest.mix_left_out, out_word.mix_left_out);
					check_field("mix_right_out", oldest.mix_right_out,
						out_word.mix_right_out);
					check_field("fetch_index", oldest.fetch_index, out_word.fetch_index);
					check_field("voice_active", oldest.voice_active, out_word.voice_active);
					check_field("buffer_last_out", oldest.buffer_last_out,
						out_word.buffer_last_out);
				end
			end
		end
		fail_count    <= mismatches;
		words_pending <= predicted_q.size();
	end

endmodule

// ===== tb/sample_voice_mixer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_voice_mixer_core_tb
// Drives the voice mixer with a directed opening and then random phases of
// start requests followed by runs of mix frames, under changing register
// settings and idle patterns. A checker beside the block predicts and
// compares every result word; this module gives the verdict.
// ----------------------------------------------------------------------------
module sample_voice_mixer_core_tb;
	import svm_pkg::*;

	// request kinds carried in req_type
	localparam logic REQ_MIX   = 1'b0;
	localparam logic REQ_START = 1'b1;

	// format_mode values: bit0 stereo, bit1 sixteen-bit
	localparam logic [1:0] FMT_MONO8    = 2'd0;
	localparam logic [1:0] FMT_STEREO8  = 2'd1;
	localparam logic [1:0] FMT_MONO16   = 2'd2;
	localparam logic [1:0] FMT_STEREO16 = 2'd3;

	// cycles to let pass once nothing is predicted any more
	localparam int SETTLE_CYCLES = 12;
	localparam int MAX_INDEX     = 20'hFFFFF;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	in_word_t               in_word   = '0;
	logic                   out_stall = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	logic      in_stall;
	logic      out_valid;
	out_word_t out_word;
	logic      cfg_ready;

	int fail_count;
	int words_pending;

	// idle percentages of the two sides, changed per phase
	int send_idle_pct = 0;
	int stall_pct     = 0;

	// data end of the current setting, used to aim start positions
	int cur_data_end = 0;

	// 8 ns clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	sample_voice_mixer_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	svm_mix_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_word       (in_word),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_word      (out_word),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.words_pending (words_pending)
	);

	// receiver side: random stall, one decision per cycle
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// hard stop well past the slowest legal run
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	// idle pattern per phase: none, sender gaps, receiver stalls, both light
	task automatic set_idle(input int mode);
		case (mode)
			1: begin
				send_idle_pct <= 76;
				stall_pct     <= 0;
			end
			2: begin
				send_idle_pct <= 0;
				stall_pct     <= 76;
			end
			3: begin
				send_idle_pct <= 11;
				stall_pct     <= 11;
			end
			default: begin
				send_idle_pct <= 0;
				stall_pct     <= 0;
			end
		endcase
	endtask

	// offer one word, with random gaps ahead of it, and wait for acceptance
	task automatic send_word(input in_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		// in_stall read here is the value the block saw at this edge
		do @(posedge clk); while (in_stall);
	endtask

	// stop offering and wait until every predicted result has come out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// random bits above a register's width, now and then
	function automatic logic [CFG_DATA_W-1:0] junk_above(input int w);
		logic [CFG_DATA_W-1:0] keep;
		if ($urandom_range(3) != 0)
			return '0;
		keep = (CFG_DATA_W'(1'b1) << w) - CFG_DATA_W'(1'b1);
		return CFG_DATA_W'($urandom) & ~keep;
	endfunction

	// write the whole register set, only ever while the block is idle
	task automatic setup_voice(
		input logic [VOL_W-1:0]   vol,
		input logic [PAN_W-1:0]   pan,
		input logic [STEP_W-1:0]  stp,
		input logic [INDEX_W-1:0] ls,
		input logic [INDEX_W-1:0] le,
		input logic [INDEX_W-1:0] de,
		input logic               en,
		input logic [1:0]         fm
	);
		reg_write(REG_VOLUME_GAIN, CFG_DATA_W'(vol) | junk_above(VOL_W));
		reg_write(REG_PAN_POSITION, CFG_DATA_W'(pan) | junk_above(PAN_W));
		reg_write(REG_STEP_INCREMENT, CFG_DATA_W'(stp));
		reg_write(REG_LOOP_START, CFG_DATA_W'(ls) | junk_above(INDEX_W));
		reg_write(REG_LOOP_END, CFG_DATA_W'(le) | junk_above(INDEX_W));
		reg_write(REG_DATA_END, CFG_DATA_W'(de) | junk_above(INDEX_W));
		reg_write(REG_LOOP_ENABLE, CFG_DATA_W'(en) | junk_above(1));
		reg_write(REG_FORMAT_MODE, CFG_DATA_W'(fm) | junk_above(2));
		cfg_valid    <= 1'b0;
		cur_data_end = int'(de);
	endtask

	// random setting with the interesting points weighted in
	task automatic setup_random();
		logic [VOL_W-1:0]   vol;
		logic [PAN_W-1:0]   pan;
		logic [STEP_W-1:0]  stp;
		logic [INDEX_W-1:0] ls;
		logic [INDEX_W-1:0] le;
		logic [INDEX_W-1:0] de;
		case ($urandom_range(4))
			0: vol = '0;
			1: vol = 14'd4096;
			2: vol = 14'd8192;
			3: vol = 14'h3FFF;
			default: vol = VOL_W'($urandom);
		endcase
		case ($urandom_range(4))
			0: pan = '0;
			1: pan = PAN_CENTER;
			2: pan = PAN_FULL;
			3: pan = 13'h1FFF;
			default: pan = PAN_W'($urandom);
		endcase
		case ($urandom_range(5))
			0: stp = '0;
			1: stp = 21'd1048576;
			default: stp = STEP_W'($urandom_range(0, 262144));
		endcase
		// short data so that wraps, restarts and stops come often
		de = INDEX_W'($urandom_range(1, 400));
		ls = INDEX_W'($urandom_range(0, de));
		le = ($urandom_range(2) == 0) ? '0 : INDEX_W'($urandom_range(1, de + 16));
		setup_voice(vol, pan, stp, ls, le, de, 1'($urandom), 2'($urandom));
	endtask

	// fully random input word
	function automatic in_word_t raw_word();
		logic [95:0] r;
		r = {$urandom, $urandom, $urandom};
		return in_word_t'(r[$bits(in_word_t)-1:0]);
	endfunction

	function automatic in_word_t start_word(input logic [INDEX_W-1:0] pos, input logic bl);
		in_word_t w;
		w                = raw_word();
		w.req_type       = REQ_START;
		w.start_position = pos;
		w.buffer_last    = bl;
		return w;
	endfunction

	function automatic in_word_t mix_word(
		input logic [SAMPLE_W-1:0] s1,
		input logic [SAMPLE_W-1:0] s2,
		input logic [SAMPLE_W-1:0] ml,
		input logic [SAMPLE_W-1:0] mr,
		input logic                bl
	);
		in_word_t w;
		w.req_type       = REQ_MIX;
		w.start_position = INDEX_W'($urandom);
		w.sample_first   = s1;
		w.sample_second  = s2;
		w.mix_left_in    = ml;
		w.mix_right_in   = mr;
		w.buffer_last    = bl;
		return w;
	endfunction

	// 16-bit value with the extremes weighted in
	function automatic logic [SAMPLE_W-1:0] pick16();
		case ($urandom_range(7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic in_word_t random_mix();
		return mix_word(pick16(), pick16(), pick16(), pick16(), 1'($urandom));
	endfunction

	// start near or inside the stored data, now and then just past its end
	function automatic logic [INDEX_W-1:0] pick_start();
		int top;
		top = cur_data_end + 3;
		if (top > MAX_INDEX)
			top = MAX_INDEX;
		return INDEX_W'($urandom_range(0, top));
	endfunction

	// mostly a start followed by a run of frames, the rest loose words
	task automatic play_phase(input int count);
		int n;
		int run;
		n = 0;
		while (n < count) begin
			if ($urandom_range(99) < 85) begin
				send_word(start_word(pick_start(), 1'($urandom)));
				n++;
				run = $urandom_range(1, 30);
				repeat (run) begin
					send_word(random_mix());
					n++;
				end
			end else begin
				send_word(raw_word());
				n++;
			end
		end
	endtask

	initial begin
		int phase;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idle(0);

		// reset setting: data end zero, a start stops at once
		send_word(mix_word(16'd1234, 16'hFFFB, 16'h7FFF, 16'h8000, 1'b1));
		send_word(start_word(20'd5, 1'b0));
		send_word(mix_word(16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 1'b0));
		drain();

		// 16-bit mono, unity centre, loop 2..6 inside data of 8, restart on
		setup_voice(14'd4096, PAN_CENTER, STEP_RST, 20'd2, 20'd6, 20'd8, 1'b1, FMT_MONO16);
		send_word(start_word(20'd0, 1'b0));
		// saturation both ways
		send_word(mix_word(16'h7FFF, 16'h0000, 16'h7FFF, 16'h8000, 1'b0));
		send_word(mix_word(16'h8000, 16'h0000, 16'h8000, 16'h7FFF, 1'b0));
		send_word(mix_word(16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 1'b1));
		send_word(mix_word(16'hFFFF, 16'h8000, 16'h0000, 16'h0000, 1'b0));
		// position reaches the loop end and wraps to the loop start
		send_word(mix_word(16'h4000, 16'h0000, 16'h0100, 16'hFF00, 1'b0));
		send_word(mix_word(16'hC000, 16'h0000, 16'h0100, 16'hFF00, 1'b0));
		// start beyond the data end restarts at the loop start
		send_word(start_word(20'd9, 1'b1));
		send_word(mix_word(16'h1234, 16'h0000, 16'h0000, 16'h0000, 1'b0));
		drain();

		// 8-bit stereo, loud, hard left, no loop: the voice stops at data end
		setup_voice(14'h3FFF, 13'd0, 21'd98304, 20'd0, 20'd0, 20'd10, 1'b0, FMT_STEREO8);
		send_word(start_word(20'd0, 1'b0));
		send_word(mix_word(16'h0000, 16'h00FF, 16'h0000, 16'h0000, 1'b0));
		send_word(mix_word(16'hFF7F, 16'hAA80, 16'h0000, 16'h0000, 1'b1));
		send_word(mix_word(16'h00FF, 16'h0000, 16'h7FFF, 16'h8000, 1'b0));
		send_word(mix_word(16'h5580, 16'hFF7F, 16'h8000, 16'h7FFF, 1'b0));
		send_word(mix_word(16'h0011, 16'h0022, 16'h0033, 16'h0044, 1'b0));
		drain();

		// random phases, the idle pattern cycling through all four
		for (phase = 0; phase < 12; phase++) begin
			set_idle(phase % 4);
			case (phase)
				3: setup_voice('0, '0, '0, '0, '0, '0, 1'b0, FMT_MONO8);
				7: setup_voice(14'h3FFF, 13'h1FFF, 21'h1FFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
					1'b1, FMT_STEREO16);
				11: setup_voice(14'd8192, PAN_FULL, 21'd1048576, '0, '0, 20'hFFFFF, 1'b0,
					FMT_MONO8);
				default: setup_random();
			endcase
			play_phase((phase == 3) ? 40 : 90);
			drain();
		end

		// let any stray result words show up before the verdict
		set_idle(0);
		drain();
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
